// File: src/svpc_pkg.sv
// package: shared types, constants and the cold-to-fire palette for the palette color unit
`default_nettype none
package svpc_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int MAX_COLORS        = 256;

    // field and datapath widths
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 9;
    localparam int IDX_W    = 8;
    localparam int RGB_W    = 24;
    localparam int LOG_W    = 13;
    localparam int QUOT_W   = 9;
    localparam int PROD_W   = DATA_W + CNT_W;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_LOG  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLORS = 2'd3;

    // opcodes
    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // 1.0 in Q16.16
    localparam logic [DATA_W-2:0] ONE_Q16 = 31'd65536;

    // how the index of an item is settled
    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_MAX,
        CLS_DIV,
        CLS_BLACK
    } cls_t;

    // per-item control that travels with the datapath
    typedef struct packed {
        logic              is_write;
        cls_t              cls;
        logic [CNT_W-1:0]  n;
        logic              wr_ok;
        logic [IDX_W-1:0]  wr_index;
        logic [RGB_W-1:0]  wr_rgb;
    } side_t;

    // 256*log2 approximation: leading-one position, then the next 8 bits
    function automatic logic [LOG_W-1:0] approx_log(input logic [DATA_W-2:0] x);
        logic [4:0]        p;
        logic [DATA_W+6:0] ext;
        p = 5'd0;
        for (int i = 0; i < DATA_W - 1; i++)
        begin
            if (x[i])
            begin
                p = 5'(i);
            end
        end
        ext = {x, 8'b0} >> p;
        return {p, ext[7:0]};
    endfunction

    localparam logic [RGB_W-1:0] COLD_FIRE [MAX_COLORS] = '{
    {8'd0,8'd172,8'd252}, {8'd0,8'd170,8'd252}, {8'd0,8'd168,8'd252}, {8'd0,8'd164,8'd252},
    {8'd0,8'd160,8'd252}, {8'd0,8'd156,8'd252}, {8'd0,8'd152,8'd252}, {8'd0,8'd152,8'd252},
    {8'd0,8'd148,8'd252}, {8'd0,8'd144,8'd252}, {8'd0,8'd140,8'd252}, {8'd0,8'd136,8'd252},
    {8'd0,8'd132,8'd252}, {8'd0,8'd132,8'd252}, {8'd0,8'd128,8'd252}, {8'd0,8'd124,8'd252},
    {8'd0,8'd120,8'd252}, {8'd0,8'd116,8'd252}, {8'd0,8'd112,8'd252}, {8'd0,8'd112,8'd252},
    {8'd0,8'd108,8'd252}, {8'd0,8'd104,8'd252}, {8'd0,8'd100,8'd252}, {8'd0,8'd96,8'd252},
    {8'd0,8'd92,8'd252}, {8'd0,8'd92,8'd252}, {8'd0,8'd88,8'd252}, {8'd0,8'd84,8'd252},
    {8'd0,8'd80,8'd252}, {8'd0,8'd76,8'd252}, {8'd0,8'd72,8'd252}, {8'd0,8'd68,8'd252},
    {8'd0,8'd64,8'd252}, {8'd0,8'd60,8'd252}, {8'd0,8'd56,8'd252}, {8'd0,8'd52,8'd252},
    {8'd0,8'd48,8'd252}, {8'd0,8'd44,8'd252}, {8'd0,8'd40,8'd252}, {8'd0,8'd36,8'd252},
    {8'd0,8'd32,8'd252}, {8'd0,8'd28,8'd252}, {8'd0,8'd24,8'd252}, {8'd0,8'd20,8'd252},
    {8'd0,8'd16,8'd252}, {8'd0,8'd12,8'd252}, {8'd0,8'd8,8'd252}, {8'd0,8'd4,8'd252},
    {8'd0,8'd4,8'd252}, {8'd4,8'd4,8'd248}, {8'd4,8'd4,8'd248}, {8'd8,8'd4,8'd244},
    {8'd8,8'd8,8'd240}, {8'd12,8'd8,8'd240}, {8'd12,8'd8,8'd236}, {8'd16,8'd8,8'd232},
    {8'd16,8'd12,8'd232}, {8'd20,8'd12,8'd228}, {8'd20,8'd12,8'd224}, {8'd24,8'd12,8'd224},
    {8'd24,8'd16,8'd220}, {8'd28,8'd16,8'd216}, {8'd28,8'd16,8'd216}, {8'd32,8'd16,8'd212},
    {8'd32,8'd20,8'd212}, {8'd36,8'd20,8'd208}, {8'd36,8'd20,8'd204}, {8'd40,8'd20,8'd204},
    {8'd40,8'd24,8'd200}, {8'd44,8'd24,8'd196}, {8'd44,8'd24,8'd196}, {8'd48,8'd24,8'd192},
    {8'd48,8'd24,8'd188}, {8'd52,8'd28,8'd188}, {8'd52,8'd28,8'd184}, {8'd56,8'd28,8'd180},
    {8'd56,8'd28,8'd180}, {8'd60,8'd32,8'd176}, {8'd60,8'd32,8'd172}, {8'd64,8'd32,8'd172},
    {8'd64,8'd32,8'd168}, {8'd68,8'd36,8'd168}, {8'd68,8'd36,8'd164}, {8'd72,8'd36,8'd160},
    {8'd72,8'd36,8'd160}, {8'd76,8'd40,8'd156}, {8'd76,8'd40,8'd152}, {8'd80,8'd40,8'd152},
    {8'd80,8'd40,8'd148}, {8'd84,8'd44,8'd144}, {8'd84,8'd44,8'd144}, {8'd88,8'd44,8'd140},
    {8'd88,8'd44,8'd136}, {8'd92,8'd48,8'd136}, {8'd92,8'd48,8'd132}, {8'd96,8'd48,8'd128},
    {8'd100,8'd48,8'd128}, {8'd100,8'd48,8'd124}, {8'd104,8'd52,8'd124}, {8'd104,8'd52,8'd120},
    {8'd108,8'd52,8'd116}, {8'd108,8'd52,8'd116}, {8'd112,8'd56,8'd112}, {8'd112,8'd56,8'd108},
    {8'd116,8'd56,8'd108}, {8'd116,8'd56,8'd104}, {8'd120,8'd60,8'd100}, {8'd120,8'd60,8'd100},
    {8'd124,8'd60,8'd96}, {8'd124,8'd60,8'd92}, {8'd128,8'd64,8'd92}, {8'd128,8'd64,8'd88},
    {8'd132,8'd64,8'd88}, {8'd132,8'd64,8'd84}, {8'd136,8'd68,8'd80}, {8'd136,8'd68,8'd80},
    {8'd140,8'd68,8'd76}, {8'd140,8'd68,8'd72}, {8'd144,8'd72,8'd72}, {8'd144,8'd72,8'd68},
    {8'd148,8'd72,8'd64}, {8'd148,8'd72,8'd64}, {8'd152,8'd72,8'd60}, {8'd152,8'd76,8'd56},
    {8'd156,8'd76,8'd56}, {8'd156,8'd76,8'd52}, {8'd160,8'd76,8'd48}, {8'd160,8'd80,8'd48},
    {8'd164,8'd80,8'd44}, {8'd164,8'd80,8'd44}, {8'd168,8'd80,8'd40}, {8'd168,8'd84,8'd36},
    {8'd172,8'd84,8'd36}, {8'd172,8'd84,8'd32}, {8'd176,8'd84,8'd28}, {8'd176,8'd88,8'd28},
    {8'd180,8'd88,8'd24}, {8'd180,8'd88,8'd20}, {8'd184,8'd88,8'd20}, {8'd184,8'd92,8'd16},
    {8'd188,8'd92,8'd12}, {8'd188,8'd92,8'd12}, {8'd192,8'd92,8'd8}, {8'd196,8'd96,8'd4},
    {8'd196,8'd96,8'd4}, {8'd196,8'd100,8'd4}, {8'd196,8'd100,8'd4}, {8'd196,8'd104,8'd4},
    {8'd200,8'd108,8'd4}, {8'd200,8'd108,8'd4}, {8'd200,8'd112,8'd4}, {8'd200,8'd112,8'd4},
    {8'd200,8'd116,8'd4}, {8'd204,8'd120,8'd4}, {8'd204,8'd120,8'd4}, {8'd204,8'd124,8'd4},
    {8'd204,8'd124,8'd4}, {8'd208,8'd128,8'd4}, {8'd208,8'd132,8'd4}, {8'd208,8'd132,8'd4},
    {8'd208,8'd136,8'd4}, {8'd208,8'd136,8'd4}, {8'd212,8'd140,8'd4}, {8'd212,8'd144,8'd4},
    {8'd212,8'd144,8'd4}, {8'd212,8'd148,8'd4}, {8'd216,8'd152,8'd4}, {8'd216,8'd152,8'd4},
    {8'd216,8'd156,8'd4}, {8'd216,8'd156,8'd4}, {8'd216,8'd160,8'd4}, {8'd220,8'd164,8'd4},
    {8'd220,8'd164,8'd4}, {8'd220,8'd168,8'd4}, {8'd220,8'd168,8'd4}, {8'd224,8'd172,8'd4},
    {8'd224,8'd176,8'd4}, {8'd224,8'd176,8'd4}, {8'd224,8'd180,8'd4}, {8'd224,8'd180,8'd4},
    {8'd228,8'd184,8'd4}, {8'd228,8'd188,8'd4}, {8'd228,8'd188,8'd4}, {8'd228,8'd192,8'd4},
    {8'd228,8'd192,8'd4}, {8'd232,8'd196,8'd4}, {8'd232,8'd200,8'd4}, {8'd232,8'd200,8'd4},
    {8'd232,8'd204,8'd4}, {8'd236,8'd208,8'd4}, {8'd236,8'd208,8'd4}, {8'd236,8'd212,8'd4},
    {8'd236,8'd212,8'd4}, {8'd236,8'd216,8'd4}, {8'd240,8'd220,8'd4}, {8'd240,8'd220,8'd4},
    {8'd240,8'd224,8'd4}, {8'd240,8'd224,8'd4}, {8'd244,8'd228,8'd4}, {8'd244,8'd232,8'd4},
    {8'd244,8'd232,8'd4}, {8'd244,8'd236,8'd4}, {8'd244,8'd236,8'd4}, {8'd248,8'd240,8'd4},
    {8'd248,8'd244,8'd4}, {8'd248,8'd244,8'd4}, {8'd248,8'd248,8'd4}, {8'd252,8'd252,8'd0},
    {8'd252,8'd252,8'd104}, {8'd252,8'd252,8'd104}, {8'd252,8'd252,8'd108}, {8'd252,8'd252,8'd112},
    {8'd252,8'd252,8'd116}, {8'd252,8'd252,8'd120}, {8'd252,8'd252,8'd120}, {8'd252,8'd252,8'd124},
    {8'd252,8'd252,8'd128}, {8'd252,8'd252,8'd132}, {8'd252,8'd252,8'd136}, {8'd252,8'd252,8'd136},
    {8'd252,8'd252,8'd140}, {8'd252,8'd252,8'd144}, {8'd252,8'd252,8'd148}, {8'd252,8'd252,8'd152},
    {8'd252,8'd252,8'd152}, {8'd252,8'd252,8'd156}, {8'd252,8'd252,8'd160}, {8'd252,8'd252,8'd164},
    {8'd252,8'd252,8'd168}, {8'd252,8'd252,8'd168}, {8'd252,8'd252,8'd172}, {8'd252,8'd252,8'd176},
    {8'd252,8'd252,8'd180}, {8'd252,8'd252,8'd184}, {8'd252,8'd252,8'd184}, {8'd252,8'd252,8'd188},
    {8'd252,8'd252,8'd192}, {8'd252,8'd252,8'd196}, {8'd252,8'd252,8'd200}, {8'd252,8'd252,8'd200},
    {8'd252,8'd252,8'd204}, {8'd252,8'd252,8'd208}, {8'd252,8'd252,8'd212}, {8'd252,8'd252,8'd216},
    {8'd252,8'd252,8'd216}, {8'd252,8'd252,8'd220}, {8'd252,8'd252,8'd224}, {8'd252,8'd252,8'd228},
    {8'd252,8'd252,8'd232}, {8'd252,8'd252,8'd232}, {8'd252,8'd252,8'd236}, {8'd252,8'd252,8'd240},
    {8'd252,8'd252,8'd244}, {8'd252,8'd252,8'd248}, {8'd252,8'd252,8'd252}, {8'd255,8'd255,8'd255}
    };

endpackage
`default_nettype wire

// File: src/svpc_ram.sv
// generic single-clock ram, one write and one registered read port
`default_nettype none
module svpc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: src/svpc_divider.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module svpc_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [svpc_pkg::PROD_W-1:0]   dividend,
    input  wire logic [svpc_pkg::DATA_W-1:0]   divisor,
    input  wire svpc_pkg::side_t               side_in,
    output logic                               out_valid,
    output logic      [svpc_pkg::QUOT_W-1:0]   quotient,
    output svpc_pkg::side_t                    side_out
);

    localparam int QW = svpc_pkg::QUOT_W;
    localparam int DW = svpc_pkg::DATA_W;

    logic              valid_reg [QW+1];
    logic [DW-1:0]     rem_reg   [QW+1];
    logic [QW-1:0]     low_reg   [QW+1];
    logic [QW-1:0]     quot_reg  [QW+1];
    logic [DW-1:0]     dvs_reg   [QW+1];
    svpc_pkg::side_t   side_reg  [QW+1];

    logic [DW:0]       trial    [QW];
    logic              ge       [QW];
    logic [DW:0]       diff     [QW];
    logic [DW-1:0]     rem_next [QW];

    // quotient fits in QW bits, so the top part of the dividend starts below the divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < QW; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            trial[k]    = {rem_reg[k], low_reg[k][QW-1]};
            ge[k]       = trial[k] >= {1'b0, dvs_reg[k]};
            diff[k]     = trial[k] - {1'b0, dvs_reg[k]};
            rem_next[k] = ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= dividend[svpc_pkg::PROD_W-1:QW];
            low_reg[0]  <= dividend[QW-1:0];
            quot_reg[0] <= '0;
            dvs_reg[0]  <= divisor;
            side_reg[0] <= side_in;
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                low_reg[k+1]  <= {low_reg[k][QW-2:0], 1'b0};
                quot_reg[k+1] <= {quot_reg[k][QW-2:0], ge[k]};
                dvs_reg[k+1]  <= dvs_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign quotient  = quot_reg[QW];
    assign side_out  = side_reg[QW];

endmodule
`default_nettype wire

// File: src/scaled_value_to_palette_color_unit.sv
// top level: maps q16.16 samples to palette index and color, with palette writes
`default_nettype none
// a map item goes through stages 1 to 3, the quotient pipeline and the output register
// throughput: one item per cycle; the whole pipe moves whenever the output register is free
// depth: stages 1 to 3, 9-stage quotient pipeline (one quotient bit per stage), ram read
// palette writes ride the pipe and hit the ram at the read stage, so order is kept
// reset: config registers take their reset values and all palette entries read as the
// cold-to-fire map at once (per-entry valid bits), no clearing pass
module scaled_value_to_palette_color_unit #(
    parameter int PALETTE_DEPTH = svpc_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [svpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [svpc_pkg::DATA_W-1:0]     cfg_data,
    // input items
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            opcode,
    input  wire logic signed [svpc_pkg::DATA_W-1:0] sample,
    input  wire logic [svpc_pkg::IDX_W-1:0]      entry_index,
    input  wire logic [7:0]                      entry_red,
    input  wire logic [7:0]                      entry_green,
    input  wire logic [7:0]                      entry_blue,
    // result items
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [svpc_pkg::IDX_W-1:0]      color_index,
    output logic      [7:0]                      red,
    output logic      [7:0]                      green,
    output logic      [7:0]                      blue
);

    localparam int DW      = svpc_pkg::DATA_W;
    localparam int NW      = svpc_pkg::CNT_W;
    localparam int LW      = svpc_pkg::LOG_W;
    localparam int PAL_ROWS = (PALETTE_DEPTH < svpc_pkg::MAX_COLORS) ?
                              PALETTE_DEPTH : svpc_pkg::MAX_COLORS;
    localparam int PAL_AW  = $clog2(PAL_ROWS);

    // global advance: everything moves when the output register can take a new item
    logic en;
    assign en       = out_ready || !out_valid;
    assign in_ready = en;

    // ---------------- configuration registers ----------------
    logic                 scale_log_reg;
    logic signed [DW-1:0] range_min_reg;
    logic signed [DW-1:0] range_max_reg;
    logic [NW-1:0]        num_colors_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_log_reg  <= 1'b1;
            range_min_reg  <= '0;
            range_max_reg  <= 32'sd65536;
            num_colors_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                svpc_pkg::REG_SCALE_LOG:  scale_log_reg  <= cfg_data[0];
                svpc_pkg::REG_RANGE_MIN:  range_min_reg  <= cfg_data;
                svpc_pkg::REG_RANGE_MAX:  range_max_reg  <= cfg_data;
                svpc_pkg::REG_NUM_COLORS: num_colors_reg <= cfg_data[NW-1:0];
                default:                  scale_log_reg  <= scale_log_reg;
            endcase
        end
    end

    // colors in use, limited by the table and by the palette depth
    logic [NW-1:0] n_lim;
    logic [NW-1:0] n_eff;
    assign n_lim = (num_colors_reg > 9'd256) ? 9'd256 : num_colors_reg;
    assign n_eff = (32'(n_lim) > PALETTE_DEPTH) ? NW'(PALETTE_DEPTH) : n_lim;

    // ---------------- stage 1: input register ----------------
    logic                 s1_valid_reg;
    logic                 s1_op_reg;
    logic signed [DW-1:0] s1_sample_reg;
    logic [7:0]           s1_index_reg;
    logic [23:0]          s1_rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg     <= opcode;
            s1_sample_reg <= sample;
            s1_index_reg  <= entry_index;
            s1_rgb_reg    <= {entry_red, entry_green, entry_blue};
        end
    end

    // differences, compares and the three log approximations, all side by side
    logic signed [DW:0] s1_va;
    logic signed [DW:0] s1_span;
    logic signed [DW:0] s1_vh;
    logic               s1_lo_pos;
    logic [LW-1:0]      s1_lv;
    logic [LW-1:0]      s1_lm;
    logic [LW-1:0]      s1_lhi;

    always_comb
    begin
        s1_va     = {s1_sample_reg[DW-1], s1_sample_reg} - {range_min_reg[DW-1], range_min_reg};
        s1_span   = {range_max_reg[DW-1], range_max_reg} - {range_min_reg[DW-1], range_min_reg};
        s1_vh     = {s1_sample_reg[DW-1], s1_sample_reg} - {range_max_reg[DW-1], range_max_reg};
        s1_lo_pos = !range_min_reg[DW-1] && (range_min_reg != '0);
        s1_lv     = svpc_pkg::approx_log(s1_sample_reg[DW-2:0]);
        s1_lm     = svpc_pkg::approx_log(s1_lo_pos ? range_min_reg[DW-2:0] : svpc_pkg::ONE_Q16);
        s1_lhi    = svpc_pkg::approx_log(range_max_reg[DW-2:0]);
    end

    // ---------------- stage 2 ----------------
    logic            s2_valid_reg;
    svpc_pkg::side_t s2_side_reg;
    logic [DW-1:0]   s2_va_reg;
    logic [DW-1:0]   s2_span_reg;
    logic            s2_span_pos_reg;
    logic            s2_v_gt_lo_reg;
    logic            s2_v_ge_hi_reg;
    logic            s2_v_pos_reg;
    logic            s2_log_reg;
    logic [LW-1:0]   s2_lv_reg;
    logic [LW-1:0]   s2_lm_reg;
    logic [LW-1:0]   s2_lhi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg.is_write <= (s1_op_reg == svpc_pkg::OP_WRITE);
            s2_side_reg.cls      <= svpc_pkg::CLS_ZERO;
            s2_side_reg.n        <= n_eff;
            s2_side_reg.wr_ok    <= 32'(s1_index_reg) < PALETTE_DEPTH;
            s2_side_reg.wr_index <= s1_index_reg;
            s2_side_reg.wr_rgb   <= s1_rgb_reg;
            s2_va_reg            <= s1_va[DW-1:0];
            s2_span_reg          <= s1_span[DW-1:0];
            s2_span_pos_reg      <= !s1_span[DW] && (s1_span != '0);
            s2_v_gt_lo_reg       <= !s1_va[DW] && (s1_va != '0);
            s2_v_ge_hi_reg       <= !s1_vh[DW];
            s2_v_pos_reg         <= !s1_sample_reg[DW-1] && (s1_sample_reg != '0);
            s2_log_reg           <= scale_log_reg;
            s2_lv_reg            <= s1_lv;
            s2_lm_reg            <= s1_lm;
            s2_lhi_reg           <= s1_lhi;
        end
    end

    // classify the item and pick the divider operands
    logic signed [LW:0] s2_num;
    logic signed [LW:0] s2_den;
    svpc_pkg::cls_t     s2_cls;
    logic [DW-1:0]      s2_a;
    logic [DW-1:0]      s2_d;
    svpc_pkg::side_t    s2_side;

    always_comb
    begin
        s2_num = {1'b0, s2_lv_reg} - {1'b0, s2_lm_reg};
        s2_den = {1'b0, s2_lhi_reg} - {1'b0, s2_lm_reg};
        s2_cls = svpc_pkg::CLS_ZERO;
        s2_a   = s2_va_reg;
        s2_d   = s2_span_reg;
        if (s2_side_reg.n == '0)
        begin
            s2_cls = svpc_pkg::CLS_BLACK;
        end
        else if (!s2_span_pos_reg || !s2_v_gt_lo_reg)
        begin
            s2_cls = svpc_pkg::CLS_ZERO;
        end
        else if (s2_v_ge_hi_reg)
        begin
            s2_cls = svpc_pkg::CLS_MAX;
        end
        else if (!s2_log_reg)
        begin
            s2_cls = svpc_pkg::CLS_DIV;
        end
        else if (!s2_v_pos_reg || (s2_den == '0))
        begin
            s2_cls = svpc_pkg::CLS_ZERO;
        end
        else if (s2_den[LW])
        begin
            // negative log span: ratio is at least one once both terms are negated
            s2_cls = s2_num[LW] ? svpc_pkg::CLS_MAX : svpc_pkg::CLS_ZERO;
        end
        else if (s2_num[LW] || (s2_num == '0))
        begin
            s2_cls = svpc_pkg::CLS_ZERO;
        end
        else
        begin
            s2_cls = svpc_pkg::CLS_DIV;
            s2_a   = DW'(s2_num[LW-1:0]);
            s2_d   = DW'(s2_den[LW-1:0]);
        end
        // side data with the class filled in
        s2_side     = s2_side_reg;
        s2_side.cls = s2_cls;
    end

    // ---------------- stage 3: operands, then multiply by n ----------------
    logic            s3_valid_reg;
    svpc_pkg::side_t s3_side_reg;
    logic [DW-1:0]   s3_a_reg;
    logic [DW-1:0]   s3_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg     <= s2_side;
            s3_a_reg        <= s2_a;
            s3_d_reg        <= s2_d;
        end
    end

    logic [svpc_pkg::PROD_W-1:0] s3_prod;
    assign s3_prod = svpc_pkg::PROD_W'(s3_a_reg) * svpc_pkg::PROD_W'(s3_side_reg.n);

    // ---------------- quotient pipeline ----------------
    logic                        dv_valid;
    logic [svpc_pkg::QUOT_W-1:0] dv_quot;
    svpc_pkg::side_t             dv_side;

    svpc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .dividend  (s3_prod),
        .divisor   (s3_d_reg),
        .side_in   (s3_side_reg),
        .out_valid (dv_valid),
        .quotient  (dv_quot),
        .side_out  (dv_side)
    );

    // final index with the clamp to n-1
    logic [NW-1:0]             nm1;
    logic [svpc_pkg::IDX_W-1:0] idx;

    always_comb
    begin
        nm1 = dv_side.n - 9'd1;
        case (dv_side.cls)
            svpc_pkg::CLS_MAX:   idx = nm1[7:0];
            svpc_pkg::CLS_DIV:   idx = (dv_quot > nm1) ? nm1[7:0] : dv_quot[7:0];
            svpc_pkg::CLS_ZERO:  idx = '0;
            svpc_pkg::CLS_BLACK: idx = '0;
            default:             idx = '0;
        endcase
    end

    // ---------------- palette: ram plus per-entry valid bits ----------------
    logic              pal_we;
    logic [PAL_AW-1:0] pal_waddr;
    logic [PAL_AW-1:0] pal_raddr;
    logic [23:0]       pal_rdata;
    logic              pal_valid_reg [PAL_ROWS];

    assign pal_we    = en && dv_valid && dv_side.is_write && dv_side.wr_ok;
    assign pal_waddr = dv_side.wr_index[PAL_AW-1:0];
    assign pal_raddr = idx[PAL_AW-1:0];

    svpc_ram #(
        .WIDTH (svpc_pkg::RGB_W),
        .DEPTH (PAL_ROWS)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (dv_side.wr_rgb),
        .re    (en),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAL_ROWS; i++)
            begin
                pal_valid_reg[i] <= 1'b0;
            end
        end
        else if (pal_we)
        begin
            pal_valid_reg[pal_waddr] <= 1'b1;
        end
    end

    // ---------------- output register ----------------
    logic                       out_valid_reg;
    logic [svpc_pkg::IDX_W-1:0] out_index_reg;
    logic                       out_black_reg;
    logic                       out_hit_reg;
    logic [23:0]                out_tbl_reg;
    logic [NW-1:0]              out_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            // palette writes end here and give no result
            out_valid_reg <= dv_valid && !dv_side.is_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_index_reg <= idx;
            out_black_reg <= (dv_side.cls == svpc_pkg::CLS_BLACK);
            out_hit_reg   <= pal_valid_reg[pal_raddr];
            out_tbl_reg   <= svpc_pkg::COLD_FIRE[idx];
            out_n_reg     <= dv_side.n;
        end
    end

    // never-written entries read as the reset map
    logic [23:0] out_rgb;
    assign out_rgb = out_black_reg ? 24'd0 : (out_hit_reg ? pal_rdata : out_tbl_reg);

    assign out_valid   = out_valid_reg;
    assign color_index = out_index_reg;
    assign red         = out_rgb[23:16];
    assign green       = out_rgb[15:8];
    assign blue        = out_rgb[7:0];

    // ---------------- assertions ----------------
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_black_reg |-> ({1'b0, out_index_reg} < out_n_reg))
        else $error("color index not below color count");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !s3_side_reg.is_write && (s3_side_reg.cls == svpc_pkg::CLS_DIV)
        |-> (s3_d_reg != '0))
        else $error("divide item with zero divisor");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid && !dv_side.is_write && (dv_side.cls == svpc_pkg::CLS_DIV)
        |-> (dv_quot <= dv_side.n))
        else $error("quotient exceeds color count");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// testbench for the palette color unit: directed table, random phases, self-checking predictor
`timescale 1ns / 100ps
module tb_top;

    // quiet cycles the watchdog accepts before giving up
    localparam int QUIET_LIMIT  = 3000;
    // pipe depth plus margin, waited out before config writes and at the end
    localparam int SETTLE_WAIT  = 24;
    localparam int PHASE_ITEMS  = 190;
    localparam int PHASE_COUNT  = 8;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [svpc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [svpc_pkg::DATA_W-1:0]    cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic signed [svpc_pkg::DATA_W-1:0] sample;
    logic [7:0]  entry_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  color_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    scaled_value_to_palette_color_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .sample      (sample),
        .entry_index (entry_index),
        .entry_red   (entry_red),
        .entry_green (entry_green),
        .entry_blue  (entry_blue),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .color_index (color_index),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        logic        op;
        logic [31:0] smp;
        logic [7:0]  ent;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        bit          typed;
        logic [31:0] want;
    } stim_row_t;

    // shadow of the block: its config and palette
    logic              shadow_log;
    logic signed [31:0] shadow_min;
    logic signed [31:0] shadow_max;
    logic [8:0]        shadow_colors;
    logic [svpc_pkg::RGB_W-1:0] shadow_palette [svpc_pkg::MAX_COLORS];

    // expected {index, red, green, blue} words, oldest first
    logic [31:0] pending_colors [$];

    int  mismatches;
    int  maps_sent;
    int  writes_sent;
    int  colors_seen;
    int  quiet_cycles;
    int  sender_idle_pct;
    int  receiver_stall_pct;

    // clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // approximate 256*log2: leading-one position then the next 8 bits
    function automatic longint log_weight(input longint x);
        int     lead;
        longint frac;
        lead = 0;
        for (int i = 0; i < 63; i++)
        begin
            if (x[i])
            begin
                lead = i;
            end
        end
        if (lead >= 8)
        begin
            frac = (x >> (lead - 8)) & 255;
        end
        else
        begin
            frac = (x << (8 - lead)) & 255;
        end
        return longint'(lead) * 256 + frac;
    endfunction

    // expected result word for a map item under the shadow state
    function automatic logic [31:0] map_sample_to_color(input logic signed [31:0] smp);
        longint n;
        longint v;
        longint lo;
        longint hi;
        longint idx;
        longint m;
        longint lm;
        longint num;
        longint den;
        logic [svpc_pkg::RGB_W-1:0] rgb;
        n = (shadow_colors > 256) ? 256 : longint'(shadow_colors);
        // no colors: black at index 0
        if (n == 0)
        begin
            return 32'd0;
        end
        v  = longint'(smp);
        lo = longint'(shadow_min);
        hi = longint'(shadow_max);
        if (hi - lo <= 0 || v <= lo)
        begin
            idx = 0;
        end
        else if (v >= hi)
        begin
            idx = n - 1;
        end
        else if (!shadow_log)
        begin
            idx = ((v - lo) * n) / (hi - lo);
        end
        else
        begin
            // nonpositive lower end is replaced by 1.0
            m = (lo <= 0) ? 65536 : lo;
            if (v <= 0)
            begin
                idx = 0;
            end
            else
            begin
                lm  = log_weight(m);
                num = log_weight(v) - lm;
                den = log_weight(hi) - lm;
                if (den == 0)
                begin
                    idx = 0;
                end
                else
                begin
                    // negative span: flip both terms
                    if (den < 0)
                    begin
                        num = -num;
                        den = -den;
                    end
                    idx = (num <= 0) ? 0 : (num * n) / den;
                end
            end
        end
        if (idx > n - 1)
        begin
            idx = n - 1;
        end
        if (idx < 0)
        begin
            idx = 0;
        end
        rgb = shadow_palette[idx];
        return {idx[7:0], rgb};
    endfunction

    // drive one item and hold it until accepted; called at a rising edge
    task automatic send_item(input logic op, input logic [31:0] smp, input logic [7:0] ent,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input bit typed, input logic [31:0] want);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        sample      <= smp;
        entry_index <= ent;
        entry_red   <= r;
        entry_green <= g;
        entry_blue  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        // item accepted at this edge: update the shadow or queue the expected color
        if (op == svpc_pkg::OP_WRITE)
        begin
            shadow_palette[ent] = {r, g, b};
            writes_sent++;
        end
        else
        begin
            pending_colors = {pending_colors, (typed ? want : map_sample_to_color(smp))};
            maps_sent++;
        end
    endtask

    // stop sending and let every expected color come out, then let the pipe empty
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_colors.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // write all four registers back to back while the block is idle
    task automatic load_config(input logic lg, input logic [31:0] lo, input logic [31:0] hi,
                               input logic [8:0] n);
        drain_pipe();
        cfg_we    <= 1'b1;
        cfg_index <= svpc_pkg::REG_SCALE_LOG;
        cfg_data  <= {31'd0, lg};
        @(posedge clk);
        cfg_index <= svpc_pkg::REG_RANGE_MIN;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= svpc_pkg::REG_RANGE_MAX;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= svpc_pkg::REG_NUM_COLORS;
        cfg_data  <= {23'd0, n};
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_log    = lg;
        shadow_min    = lo;
        shadow_max    = hi;
        shadow_colors = n;
    endtask

    // random sample biased toward the current interval and its edges
    function automatic logic [31:0] pick_sample();
        longint lo;
        longint hi;
        logic [63:0] r;
        int sel;
        lo  = longint'(shadow_min);
        hi  = longint'(shadow_max);
        sel = $urandom_range(99);
        r   = {$urandom, $urandom};
        if (sel < 55 && hi > lo)
        begin
            return 32'(lo + longint'(r % 64'(hi - lo + 1)));
        end
        else if (sel < 70)
        begin
            case ($urandom_range(5))
                0: return 32'(lo);
                1: return 32'(lo + 1);
                2: return 32'(hi);
                3: return 32'(hi - 1);
                4: return 32'h0001_0000;
                default: return 32'h0000_0000;
            endcase
        end
        return r[31:0];
    endfunction

    // receiver: random back-pressure at the current stall rate
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // result checker: compare each accepted color with the oldest expectation
    always @(posedge clk)
    begin
        logic [31:0] want;
        logic [31:0] got;
        if (rst_n && out_valid && out_ready)
        begin
            got = {color_index, red, green, blue};
            colors_seen++;
            if (pending_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected color: index %0d rgb %0d %0d %0d",
                             color_index, red, green, blue);
                end
            end
            else
            begin
                want = pending_colors.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("color mismatch: expected index %0d rgb %0d %0d %0d, got index %0d rgb %0d %0d %0d",
                                 want[31:24], want[23:16], want[15:8], want[7:0],
                                 color_index, red, green, blue);
                    end
                end
            end
        end
    end

    // watchdog: count cycles where neither side moves an item
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("scaled_value_to_palette_color_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows [$];
        logic [31:0] lo;
        logic [31:0] hi;
        int items;
        // known values on every input from time zero
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = svpc_pkg::REG_SCALE_LOG;
        cfg_data           = '0;
        in_valid           = 1'b0;
        opcode             = svpc_pkg::OP_MAP;
        sample             = '0;
        entry_index        = '0;
        entry_red          = '0;
        entry_green        = '0;
        entry_blue         = '0;
        out_ready          = 1'b0;
        mismatches         = 0;
        maps_sent          = 0;
        writes_sent        = 0;
        colors_seen        = 0;
        quiet_cycles       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // shadow starts at the reset values
        shadow_log    = 1'b1;
        shadow_min    = 32'sd0;
        shadow_max    = 32'sd65536;
        shadow_colors = 9'd256;
        for (int i = 0; i < svpc_pkg::MAX_COLORS; i++)
        begin
            shadow_palette[i] = svpc_pkg::COLD_FIRE[i];
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset config (log scale, interval 0 to 1.0, 256 colors)
        // at the lower end: first entry of the cold-to-fire map
        rows = {rows, stim_row_t'{svpc_pkg::OP_MAP, 32'h0000_0000, 8'd0, 8'd0, 8'd0, 8'd0,
                                  1, {8'd0, 8'd0, 8'd172, 8'd252}}};
        // at the upper end: last entry, white
        rows = {rows, stim_row_t'{svpc_pkg::OP_MAP, 32'h0001_0000, 8'd0, 8'd0, 8'd0, 8'd0,
                                  1, {8'd255, 8'd255, 8'd255, 8'd255}}};
        rows = {rows, stim_row_t'{svpc_pkg::OP_MAP, 32'h7FFF_FFFF, 8'd0, 8'd0, 8'd0, 8'd0,
                                  1, {8'd255, 8'd255, 8'd255, 8'd255}}};
        rows = {rows, stim_row_t'{svpc_pkg::OP_MAP, 32'h8000_0000, 8'd0, 8'd0, 8'd0, 8'd0,
                                  1, {8'd0, 8'd0, 8'd172, 8'd252}}};
        // inside a flat log span: index 0; then samples outside the interval at either end
        rows = {rows, stim_row_t'{svpc_pkg::OP_MAP, 32'h0000_8000, 8'd0, 8'd0, 8'd0, 8'd0,
                                  0, 32'd0}};
        rows = {rows, stim_row_t'{svpc_pkg::OP_MAP, 32'h0000_0001, 8'd0, 8'd0, 8'd0, 8'd0,
                                  0, 32'd0}};
        rows = {rows, stim_row_t'{svpc_pkg::OP_MAP, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0, 8'd0,
                                  0, 32'd0}};
        rows = {rows, stim_row_t'{svpc_pkg::OP_MAP, 32'h5555_5555, 8'd0, 8'd0, 8'd0, 8'd0,
                                  0, 32'd0}};
        rows = {rows, stim_row_t'{svpc_pkg::OP_MAP, 32'hAAAA_AAAA, 8'd0, 8'd0, 8'd0, 8'd0,
                                  0, 32'd0}};
        // palette writes, the first two followed by reads of the same entries
        rows = {rows, stim_row_t'{svpc_pkg::OP_WRITE, 32'hFFFF_FFFF, 8'd0, 8'd1, 8'd2, 8'd3,
                                  0, 32'd0}};
        rows = {rows, stim_row_t'{svpc_pkg::OP_MAP, 32'h0000_0000, 8'd0, 8'd0, 8'd0, 8'd0,
                                  1, {8'd0, 8'd1, 8'd2, 8'd3}}};
        rows = {rows, stim_row_t'{svpc_pkg::OP_WRITE, 32'h0000_0000, 8'd255, 8'hAA, 8'h55,
                                  8'hFF, 0, 32'd0}};
        rows = {rows, stim_row_t'{svpc_pkg::OP_MAP, 32'h0001_0000, 8'd0, 8'd0, 8'd0, 8'd0,
                                  1, {8'd255, 8'hAA, 8'h55, 8'hFF}}};
        rows = {rows, stim_row_t'{svpc_pkg::OP_WRITE, 32'h1234_5678, 8'hAA, 8'h55, 8'hAA,
                                  8'h55, 0, 32'd0}};
        rows = {rows, stim_row_t'{svpc_pkg::OP_WRITE, 32'h0000_0000, 8'h55, 8'hFF, 8'h00,
                                  8'hAA, 0, 32'd0}};
        rows = {rows, stim_row_t'{svpc_pkg::OP_MAP, 32'h0000_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                  0, 32'd0}};
        foreach (rows[i])
        begin
            send_item(rows[i].op, rows[i].smp, rows[i].ent, rows[i].r, rows[i].g, rows[i].b,
                      rows[i].typed, rows[i].want);
        end

        // random phases: each loads a config and one of four idle patterns
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                // linear over 0..100.0
                0: load_config(1'b0, 32'h0000_0000, 32'h0064_0000, 9'd256);
                // log up to the largest value
                1: load_config(1'b1, 32'h0000_0000, 32'h7FFF_FFFF, 9'd256);
                // linear over the whole number range
                2: load_config(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 9'd256);
                // log with the upper end below 1.0: negative span
                3: load_config(1'b1, 32'hFFFF_0000, 32'h0000_03E8, 9'd256);
                // single color, tiny positive lower end
                4: load_config(1'b1, 32'h0000_0003, 32'h4000_0000, 9'd1);
                // no colors: black
                5: load_config(1'b0, 32'hFFFF_FC18, 32'h0000_03E8, 9'd0);
                // count above 256 is clamped, then a reversed interval later in the phase
                6: load_config(1'b1, 32'h0000_0100, 32'h0032_0000, 9'd511);
                default:
                begin
                    lo = $urandom;
                    hi = $urandom;
                    load_config($urandom_range(1), lo, hi, 9'($urandom_range(300)));
                end
            endcase
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
                default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
            endcase
            for (items = 0; items < PHASE_ITEMS; items++)
            begin
                // in phase 2, halfway through, the sender holds off until every expected color is back
                if (items == PHASE_ITEMS / 2 && phase == 2)
                begin
                    drain_pipe();
                end
                if (items == PHASE_ITEMS / 2 && phase == 6)
                begin
                    // reversed interval: always index 0
                    load_config(1'b0, 32'h0004_0000, 32'h0001_0000, 9'd256);
                end
                if ($urandom_range(99) < 12)
                begin
                    send_item(svpc_pkg::OP_WRITE, $urandom, 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 0, 32'd0);
                end
                else
                begin
                    send_item(svpc_pkg::OP_MAP, pick_sample(), 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 0, 32'd0);
                end
            end
        end

        // end of run: everything back, then let the pipe settle
        drain_pipe();
        if (pending_colors.size() != 0)
        begin
            mismatches++;
        end
        $display("run covered %0d map items and %0d palette writes over %0d configs",
                 maps_sent, writes_sent, PHASE_COUNT + 2);
        $display("%0d colors checked, %0d mismatches", colors_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("scaled_value_to_palette_color_unit: match");
        end
        else
        begin
            $display("scaled_value_to_palette_color_unit: mismatch");
        end
        $finish;
    end

endmodule
